@@ rtl/button_edge_and_quadrature_decoder_macros.svh @@
// assertion macros for the port checker
`ifndef BUTTON_EDGE_AND_QUADRATURE_DECODER_MACROS_SVH
`define BUTTON_EDGE_AND_QUADRATURE_DECODER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BQD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bqd_pkg.sv @@
`default_nettype none
package bqd_pkg;

  localparam int unsigned LevelWidth = 32;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned QueryWidth = 5;

  // gray code contribution of each encoder pin
  localparam logic [1:0] CODE_OUT1 = 2'b11;
  localparam logic [1:0] CODE_OUT2 = 2'b01;

  // step encodings, two's complement
  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_UP   = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN = 2'sb11;

  localparam logic [CountWidth-1:0] HOLD_LIMIT_RESET = 8'd100;

  // direction mark bits of the radio filter
  localparam int unsigned MARK_DOWN = 0;
  localparam int unsigned MARK_UP   = 1;

  // decoded encoder movement
  typedef struct packed {
    logic stepped;
    logic up;
  } quad_step_t;

endpackage
`default_nettype wire

@@ rtl/button_edge_and_quadrature_decoder.sv @@
// channel | direction | handshake           | payload
// in      | sink      | in_valid_i/stall_o  | raw buttons, sample flag, pins, query
// out     | source    | out_valid_o/stall_i | levels, held, pressed, released, steps, hold
// cfg     | sink      | cfg_valid_i/ready_o | long hold limit
//
// one tick per cycle sustained unless out stalls: an input register feeds short logic into the result register
// a tick taken on in passes the input register and then the result register to the out ports
// a transfer on in is taken while a result waits, as long as the input register is empty
// async active-low reset clears state, the hold limit comes up at 100
// cfg is always ready and is expected only while no tick is in flight
`default_nettype none
module button_edge_and_quadrature_decoder #(
  parameter int unsigned NUM_BUTTONS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input tick
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bqd_pkg::LevelWidth-1:0] raw_buttons_i,
  input  logic                           encoder_sample_valid_i,
  input  logic [1:0]                     radio_pins_i,
  input  logic [1:0]                     panel_pins_i,
  input  logic [bqd_pkg::QueryWidth-1:0] query_index_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bqd_pkg::LevelWidth-1:0] levels_o,
  output logic [bqd_pkg::LevelWidth-1:0] held_o,
  output logic [bqd_pkg::LevelWidth-1:0] pressed_o,
  output logic [bqd_pkg::LevelWidth-1:0] released_o,
  output logic signed [1:0]              radio_step_o,
  output logic signed [1:0]              panel_step_o,
  output logic [bqd_pkg::CountWidth-1:0] hold_time_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bqd_pkg::CountWidth-1:0] cfg_data_i
);
  import bqd_pkg::*;

  // levels above the button count read as released
  localparam logic [LevelWidth-1:0] LevelMask = (NUM_BUTTONS >= LevelWidth) ? '1 :
                                                LevelWidth'((64'd1 << NUM_BUTTONS) - 64'd1);

  // handshake
  logic in_xfer;
  logic out_free;
  logic s1_adv;

  // input register
  logic                  s1_valid_q;
  logic [LevelWidth-1:0] s1_buttons_q;
  logic                  s1_sample_q;
  logic [1:0]            s1_radio_q;
  logic [1:0]            s1_panel_q;
  logic [QueryWidth-1:0] s1_query_q;

  // tick state
  logic [LevelWidth-1:0] prev_levels_q;
  logic [CountWidth-1:0] limit_q;
  logic [1:0]            marks_q;
  logic [1:0]            marks_d;

  // combinational results
  logic [LevelWidth-1:0] lv;
  logic [LevelWidth-1:0] held;
  logic signed [1:0]     radio_d;
  logic signed [1:0]     panel_d;
  logic [CountWidth-1:0] hold_time;
  quad_step_t            radio_mv;
  quad_step_t            panel_mv;
  logic                  dec_en;

  // result register
  logic                  out_valid_q;
  logic [LevelWidth-1:0] levels_q;
  logic [LevelWidth-1:0] held_q;
  logic [LevelWidth-1:0] pressed_q;
  logic [LevelWidth-1:0] released_q;
  logic signed [1:0]     radio_q;
  logic signed [1:0]     panel_q;
  logic [CountWidth-1:0] hold_time_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer || s1_adv) begin
      s1_valid_q <= in_xfer;
    end
  end

  // tick payload, taken only on a transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_buttons_q <= raw_buttons_i;
      s1_sample_q  <= encoder_sample_valid_i;
      s1_radio_q   <= radio_pins_i;
      s1_panel_q   <= panel_pins_i;
      s1_query_q   <= query_index_i;
    end
  end

  // edge detection against last tick's levels
  assign lv   = s1_buttons_q & LevelMask;
  assign held = prev_levels_q & lv;

  // phases move only when the tick leaves the input register with a fresh sample
  assign dec_en = s1_adv && s1_sample_q;

  bqd_quad_decoder u_radio_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (dec_en),
    .pins_i (s1_radio_q),
    .step_o (radio_mv)
  );

  bqd_quad_decoder u_panel_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (dec_en),
    .pins_i (s1_panel_q),
    .step_o (panel_mv)
  );

  bqd_hold_bank #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_hold_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_en_i    (s1_adv),
    .held_i      (held),
    .limit_i     (limit_q),
    .query_i     (s1_query_q),
    .hold_time_o (hold_time)
  );

  // radio filter: one step per direction until a suppressed step or a pause clears the marks; panel steps pass through
  always_comb begin
    radio_d = STEP_NONE;
    panel_d = STEP_NONE;
    marks_d = marks_q;
    if (s1_sample_q) begin
      marks_d = 2'b00;
      if (radio_mv.stepped && !radio_mv.up && !marks_q[MARK_DOWN]) begin
        marks_d[MARK_DOWN] = 1'b1;
        radio_d = STEP_DOWN;
      end else if (radio_mv.stepped && radio_mv.up && !marks_q[MARK_UP]) begin
        marks_d[MARK_UP] = 1'b1;
        radio_d = STEP_UP;
      end
      if (panel_mv.stepped) begin
        panel_d = panel_mv.up ? STEP_UP : STEP_DOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_levels_q <= '0;
      marks_q       <= 2'b00;
    end else if (s1_adv) begin
      prev_levels_q <= lv;
      marks_q       <= marks_d;
    end
  end

  // hold limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HOLD_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // result payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      levels_q    <= lv;
      held_q      <= held;
      pressed_q   <= ~prev_levels_q & lv;
      released_q  <= prev_levels_q & ~lv;
      radio_q     <= radio_d;
      panel_q     <= panel_d;
      hold_time_q <= hold_time;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign levels_o     = levels_q;
  assign held_o       = held_q;
  assign pressed_o    = pressed_q;
  assign released_o   = released_q;
  assign radio_step_o = radio_q;
  assign panel_step_o = panel_q;
  assign hold_time_o  = hold_time_q;

endmodule
`default_nettype wire

@@ rtl/bqd_quad_decoder.sv @@
`default_nettype none
module bqd_quad_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [1:0]        pins_i,
  output bqd_pkg::quad_step_t step_o
);
  import bqd_pkg::*;

  logic [1:0] phase_q;
  logic [1:0] code;
  logic [1:0] diff;

  always_comb begin
    code = (pins_i[0] ? CODE_OUT1 : 2'b00) ^ (pins_i[1] ? CODE_OUT2 : 2'b00);
    diff = phase_q - code;
    step_o.stepped = diff[0];
    step_o.up      = diff[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'b00;
    end else if (en_i && diff[0]) begin
      phase_q <= code;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bqd_hold_bank.sv @@
`default_nettype none
module bqd_hold_bank #(
  parameter int unsigned NUM_BUTTONS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             upd_en_i,
  input  logic [bqd_pkg::LevelWidth-1:0]   held_i,
  input  logic [bqd_pkg::CountWidth-1:0]   limit_i,
  input  logic [bqd_pkg::QueryWidth-1:0]   query_i,
  output logic [bqd_pkg::CountWidth-1:0]   hold_time_o
);
  import bqd_pkg::*;

  // buttons past the level word never count, so they need no storage
  localparam int unsigned NumCnt = (NUM_BUTTONS > LevelWidth) ? LevelWidth : NUM_BUTTONS;

  logic [CountWidth-1:0] cnt_q [NumCnt];
  logic [CountWidth-1:0] cnt_d [NumCnt];

  always_comb begin
    logic [CountWidth-1:0] inc;
    for (int i = 0; i < NumCnt; i++) begin
      inc = held_i[i] ? cnt_q[i] + 1'b1 : '0;
      cnt_d[i] = (inc > limit_i) ? '0 : inc;
    end
  end

  // updated count of the queried button, zero past the bank
  always_comb begin
    hold_time_o = '0;
    for (int i = 0; i < NumCnt; i++) begin
      if (query_i == QueryWidth'(i)) begin
        hold_time_o = cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCnt; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd_en_i) begin
      for (int i = 0; i < NumCnt; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bqd_port_checker.sv @@
`default_nettype none
`include "button_edge_and_quadrature_decoder_macros.svh"
module bqd_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [31:0]       levels_o,
  input logic [31:0]       held_o,
  input logic [31:0]       pressed_o,
  input logic [31:0]       released_o,
  input logic signed [1:0] radio_step_o,
  input logic signed [1:0] panel_step_o,
  input logic [7:0]        hold_time_o
);

  // a stalled result stays put
  `BQD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(levels_o) && $stable(hold_time_o), "stalled result changed")

  // held and pressed split the current levels, released lies outside them
  `BQD_ASSERT_NOW(a_edge_split, out_valid_o,
    ((held_o | pressed_o) == levels_o) && ((held_o & pressed_o) == 32'd0) &&
    ((released_o & levels_o) == 32'd0), "inconsistent edge vectors")

  // steps are only -1, 0 or +1
  `BQD_ASSERT_NOW(a_step_range, out_valid_o,
    (radio_step_o != 2'sb10) && (panel_step_o != 2'sb10), "step out of range")

  // an empty result register never backs up the input
  `BQD_ASSERT_NOW(a_no_false_stall, !out_valid_o, !in_stall_o, "input stalled with no result pending")

endmodule

bind button_edge_and_quadrature_decoder bqd_port_checker u_bqd_port_checker (.*);
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bqd_pkg::*;

  localparam int unsigned NUM_BUTTONS = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // the sink stops taking results for a long stretch once this many have arrived
  localparam int unsigned LONG_HOLD_AT = 400;
  localparam int unsigned LONG_HOLD_CYCLES = 150;

  // one tick as driven on the input ports
  typedef struct packed {
    logic [LevelWidth-1:0] buttons;
    logic                  sample;
    logic [1:0]            radio;
    logic [1:0]            panel;
    logic [QueryWidth-1:0] query;
  } tick_t;

  // one result as seen on the output ports
  typedef struct packed {
    logic [LevelWidth-1:0] levels;
    logic [LevelWidth-1:0] held;
    logic [LevelWidth-1:0] pressed;
    logic [LevelWidth-1:0] released;
    logic signed [1:0]     radio;
    logic signed [1:0]     panel;
    logic [CountWidth-1:0] hold;
  } result_t;

  // directed row: the tick, and a hand-written result where one is given
  typedef struct packed {
    tick_t   tick;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [LevelWidth-1:0] raw_buttons_i;
  logic                  encoder_sample_valid_i;
  logic [1:0]            radio_pins_i;
  logic [1:0]            panel_pins_i;
  logic [QueryWidth-1:0] query_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [LevelWidth-1:0] levels_o;
  logic [LevelWidth-1:0] held_o;
  logic [LevelWidth-1:0] pressed_o;
  logic [LevelWidth-1:0] released_o;
  logic signed [1:0]     radio_step_o;
  logic signed [1:0]     panel_step_o;
  logic [CountWidth-1:0] hold_time_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CountWidth-1:0] cfg_data_i;

  button_edge_and_quadrature_decoder #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .raw_buttons_i         (raw_buttons_i),
    .encoder_sample_valid_i(encoder_sample_valid_i),
    .radio_pins_i          (radio_pins_i),
    .panel_pins_i          (panel_pins_i),
    .query_index_i         (query_index_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .levels_o              (levels_o),
    .held_o                (held_o),
    .pressed_o             (pressed_o),
    .released_o            (released_o),
    .radio_step_o          (radio_step_o),
    .panel_step_o          (panel_step_o),
    .hold_time_o           (hold_time_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_data_i            (cfg_data_i)
  );

  // predictor copy of the block state
  logic [CountWidth-1:0] hold_limit;
  logic [LevelWidth-1:0] seen_levels;
  logic [CountWidth-1:0] hold_cnt [NUM_BUTTONS];
  logic [1:0]            radio_ph;
  logic [1:0]            panel_ph;
  logic [1:0]            radio_marks;

  // results still owed by the block, oldest first
  result_t expected_results [$];

  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned cycle_count;
  bit          send_calm;
  bit          sink_calm;

  // stimulus walkers: levels last sent, encoder positions and their drift
  logic [LevelWidth-1:0] stim_levels;
  logic [1:0]            radio_pos;
  logic [1:0]            panel_pos;
  logic [1:0]            radio_dir;
  logic [1:0]            panel_dir;

  // directed ticks; the encoders start at phase 0 after reset
  dir_row_t directed_rows [18] = '{
    // all buttons go down at once, nothing held yet
    '{'{32'hFFFF_FFFF, 1'b0, 2'b00, 2'b00, 5'd0}, 1'b1,
      '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, STEP_NONE, STEP_NONE, 8'd0}},
    // all held, pins move but the sample flag is low so no step
    '{'{32'hFFFF_FFFF, 1'b0, 2'b11, 2'b11, 5'd31}, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, STEP_NONE, STEP_NONE, 8'd1}},
    // all released
    '{'{32'h0000_0000, 1'b0, 2'b00, 2'b00, 5'd31}, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, STEP_NONE, STEP_NONE, 8'd0}},
    // up on both, then a second radio up is swallowed
    '{'{32'hAAAA_AAAA, 1'b1, 2'b10, 2'b10, 5'd1}, 1'b0, NO_RESULT},
    '{'{32'hAAAA_AAAA, 1'b1, 2'b11, 2'b11, 5'd1}, 1'b0, NO_RESULT},
    // radio up passes again after the swallow, panel goes down
    '{'{32'h5555_5555, 1'b1, 2'b01, 2'b10, 5'd0}, 1'b0, NO_RESULT},
    // pins unchanged: no step on either
    '{'{32'h5555_5555, 1'b1, 2'b01, 2'b10, 5'd2}, 1'b0, NO_RESULT},
    // radio down, down (swallowed), down
    '{'{32'h8000_0001, 1'b1, 2'b11, 2'b00, 5'd31}, 1'b0, NO_RESULT},
    '{'{32'h8000_0001, 1'b1, 2'b10, 2'b00, 5'd0}, 1'b0, NO_RESULT},
    '{'{32'h8000_0001, 1'b1, 2'b00, 2'b00, 5'd31}, 1'b0, NO_RESULT},
    // two-phase jump: no step, phase kept
    '{'{32'h7FFF_FFFE, 1'b1, 2'b11, 2'b11, 5'd30}, 1'b0, NO_RESULT},
    // stale sample is ignored
    '{'{32'h7FFF_FFFE, 1'b0, 2'b01, 2'b01, 5'd30}, 1'b0, NO_RESULT},
    '{'{32'h7FFF_FFFE, 1'b1, 2'b01, 2'b11, 5'd1}, 1'b0, NO_RESULT},
    '{'{32'h7FFF_FFFE, 1'b1, 2'b00, 2'b01, 5'd1}, 1'b0, NO_RESULT},
    '{'{32'hFFFF_FFFF, 1'b1, 2'b10, 2'b00, 5'd0}, 1'b0, NO_RESULT},
    '{'{32'hFFFF_FFFF, 1'b1, 2'b11, 2'b11, 5'd31}, 1'b0, NO_RESULT},
    '{'{32'hFFFF_FFFF, 1'b1, 2'b01, 2'b01, 5'd15}, 1'b0, NO_RESULT},
    '{'{32'h0000_0000, 1'b1, 2'b00, 2'b00, 5'd31}, 1'b0, NO_RESULT}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // gray decode of one pin pair against the stored phase
  function automatic logic signed [1:0] gray_step(inout logic [1:0] ph,
                                                  input logic [1:0] pins);
    logic [1:0] code;
    logic [1:0] d;
    code = (pins[0] ? CODE_OUT1 : 2'b00) ^ (pins[1] ? CODE_OUT2 : 2'b00);
    d = ph - code;
    if (!d[0]) return STEP_NONE;
    ph = code;
    return d[1] ? STEP_UP : STEP_DOWN;
  endfunction

  // advances the predictor by one tick and returns the result it owes
  function automatic result_t predict_tick(input tick_t t);
    result_t r;
    logic [LevelWidth-1:0] lv;
    logic signed [1:0] rs;
    for (int i = 0; i < LevelWidth; i++) lv[i] = (i < NUM_BUTTONS) ? t.buttons[i] : 1'b0;
    r.levels   = lv;
    r.held     = seen_levels & lv;
    r.pressed  = ~seen_levels & lv;
    r.released = seen_levels & ~lv;
    seen_levels = lv;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      // 8-bit counter wraps first, then the limit check
      if (i < LevelWidth && r.held[i]) hold_cnt[i] = hold_cnt[i] + 8'd1;
      else hold_cnt[i] = '0;
      if (hold_cnt[i] > hold_limit) hold_cnt[i] = '0;
    end
    r.radio = STEP_NONE;
    r.panel = STEP_NONE;
    if (t.sample) begin
      rs = gray_step(radio_ph, t.radio);
      // radio passes every other step of an unbroken run in one direction
      if (rs == STEP_DOWN && !radio_marks[MARK_DOWN]) begin
        radio_marks = '0;
        radio_marks[MARK_DOWN] = 1'b1;
        r.radio = STEP_DOWN;
      end else if (rs == STEP_UP && !radio_marks[MARK_UP]) begin
        radio_marks = '0;
        radio_marks[MARK_UP] = 1'b1;
        r.radio = STEP_UP;
      end else begin
        radio_marks = '0;
      end
      r.panel = gray_step(panel_ph, t.panel);
    end
    r.hold = (t.query < NUM_BUTTONS) ? hold_cnt[t.query] : '0;
    return r;
  endfunction

  // pin pair that decodes to a given phase
  function automatic logic [1:0] code_pins(input logic [1:0] code);
    case (code)
      2'd0: return 2'b00;
      2'd1: return 2'b10;
      2'd2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offers one tick after a random gap and books its result on transfer
  task automatic send_tick(input tick_t t, input logic typed, input result_t typed_res);
    int unsigned gap;
    result_t r;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    raw_buttons_i          <= t.buttons;
    encoder_sample_valid_i <= t.sample;
    radio_pins_i           <= t.radio;
    panel_pins_i           <= t.panel;
    query_index_i          <= t.query;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_tick(t);
    expected_results.push_back(typed ? typed_res : r);
    stim_levels = t.buttons;
  endtask

  // limit may only change once the pipe has drained
  task automatic set_hold_limit(input logic [CountWidth-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    hold_limit = value;
  endtask

  // mostly slow-changing buttons and encoder walks, some plain noise
  task automatic run_random(input int unsigned count);
    tick_t t;
    int unsigned mode;
    logic [LevelWidth-1:0] flips;
    for (int unsigned n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      t.query = QueryWidth'($urandom_range(0, 31));
      if (mode == 0) begin
        t.buttons = $urandom;
        t.sample  = 1'($urandom_range(0, 1));
        t.radio   = 2'($urandom_range(0, 3));
        t.panel   = 2'($urandom_range(0, 3));
      end else begin
        if (mode == 1) flips = $urandom & $urandom;
        else if (mode <= 4) flips = '0;
        else flips = $urandom & $urandom & $urandom & $urandom;
        t.buttons = stim_levels ^ flips;
        t.sample  = ($urandom_range(0, 7) != 0);
        // direction changes now and then, with pauses and skipped phases
        if ($urandom_range(0, 15) == 0) radio_dir = -radio_dir;
        if ($urandom_range(0, 15) == 0) panel_dir = -panel_dir;
        case ($urandom_range(0, 7))
          0: ;
          1: radio_pos = radio_pos + 2'd2;
          default: radio_pos = radio_pos + radio_dir;
        endcase
        case ($urandom_range(0, 7))
          0: ;
          1: panel_pos = panel_pos + 2'd2;
          default: panel_pos = panel_pos + panel_dir;
        endcase
        t.radio = code_pins(radio_pos);
        t.panel = code_pins(panel_pos);
      end
      send_tick(t, 1'b0, NO_RESULT);
    end
  endtask

  // result side: random stalls, one long hold-off, in-order checking
  initial begin : result_sink
    int unsigned stall_cycles;
    result_t got;
    result_t want;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      stall_cycles = sink_calm ? 0 : $urandom_range(0, 17);
      if (results_seen == LONG_HOLD_AT) stall_cycles = LONG_HOLD_CYCLES;
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      got = '{levels_o, held_o, pressed_o, released_o, radio_step_o, panel_step_o,
              hold_time_o};
      if (expected_results.size() == 0) begin
        report_mismatch("result with no tick pending", got.levels, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.levels !== want.levels) report_mismatch("levels", got.levels, want.levels);
        if (got.held !== want.held) report_mismatch("held", got.held, want.held);
        if (got.pressed !== want.pressed)
          report_mismatch("pressed", got.pressed, want.pressed);
        if (got.released !== want.released)
          report_mismatch("released", got.released, want.released);
        if (got.radio !== want.radio)
          report_mismatch("radio_step", {30'b0, got.radio}, {30'b0, want.radio});
        if (got.panel !== want.panel)
          report_mismatch("panel_step", {30'b0, got.panel}, {30'b0, want.panel});
        if (got.hold !== want.hold)
          report_mismatch("hold_time", {24'b0, got.hold}, {24'b0, want.hold});
      end
    end
  end

  // watchdog
  initial begin : cycle_watch
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    tick_t t;
    rst_ni                 <= 1'b0;
    in_valid_i             <= 1'b0;
    raw_buttons_i          <= '0;
    encoder_sample_valid_i <= 1'b0;
    radio_pins_i           <= 2'b00;
    panel_pins_i           <= 2'b00;
    query_index_i          <= '0;
    cfg_valid_i            <= 1'b0;
    cfg_data_i             <= '0;
    mismatch_count = 0;
    results_seen   = 0;
    send_calm      = 1'b0;
    sink_calm      = 1'b0;
    hold_limit     = HOLD_LIMIT_RESET;
    seen_levels    = '0;
    radio_ph       = 2'd0;
    panel_ph       = 2'd0;
    radio_marks    = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) hold_cnt[i] = '0;
    stim_levels = '0;
    radio_pos   = 2'd0;
    panel_pos   = 2'd0;
    radio_dir   = 2'd1;
    panel_dir   = 2'd3;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks under the reset limit
    foreach (directed_rows[k])
      send_tick(directed_rows[k].tick, directed_rows[k].typed, directed_rows[k].res);
    run_random(250);

    // limit 0: every count clears right away
    set_hold_limit(8'd0);
    run_random(120);

    // limit 255: hold everything long enough for the 8-bit count to wrap
    set_hold_limit(8'd255);
    for (int n = 0; n < 262; n++) begin
      t.buttons = '1;
      t.sample  = 1'($urandom_range(0, 1));
      t.radio   = 2'($urandom_range(0, 3));
      t.panel   = 2'($urandom_range(0, 3));
      t.query   = QueryWidth'($urandom_range(0, 31));
      send_tick(t, 1'b0, NO_RESULT);
    end
    run_random(120);

    // short limit so the wrap happens often
    set_hold_limit(8'd7);
    run_random(200);

    set_hold_limit(8'($urandom_range(1, 254)));
    run_random(150);

    set_hold_limit(8'd1);
    run_random(130);

    // drain
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bqd_pkg.sv
rtl/bqd_quad_decoder.sv
rtl/bqd_hold_bank.sv
rtl/button_edge_and_quadrature_decoder.sv
rtl/bqd_port_checker.sv
tb/sv/testbench.sv
